// ===== hdl/ctli_pkg.sv =====
// ---------------------------------------------------------------------------
// ctli_pkg
// Shared constants, register codes and stage types of the complex table
// linear interpolator.
// ---------------------------------------------------------------------------
package ctli_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int FRAC_BITS   = 16;

   localparam int COORD_W     = 32;
   localparam int SAMPLE_W    = 16;
   localparam int INDEX_W     = 10;
   localparam int COUNT_W     = 11;
   localparam int PROD_W      = 2 * COORD_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic signed [COORD_W-1:0] X_MIN_RESET    = 32'sd0;
   localparam logic [COORD_W-1:0]        INV_STEP_RESET = 32'd65536;
   localparam logic [COUNT_W-1:0]        ENTRIES_RESET  = 11'd1024;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_X_MIN          = 2'd0,
      REG_INV_STEP       = 2'd1,
      REG_ENTRIES_IN_USE = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_min;
      logic [COORD_W-1:0]        inv_step;
      logic [COUNT_W-1:0]        entries_in_use;
   } cfg_type;

   typedef struct packed {
      logic                       is_query;
      logic signed [COORD_W:0]    diff;
      logic [INDEX_W-1:0]         entry_index;
      logic signed [SAMPLE_W-1:0] entry_re;
      logic signed [SAMPLE_W-1:0] entry_im;
   } s1_type;

   typedef struct packed {
      logic                       is_query;
      logic                       below;
      logic [PROD_W-1:0]          prod;
      logic [INDEX_W-1:0]         entry_index;
      logic signed [SAMPLE_W-1:0] entry_re;
      logic signed [SAMPLE_W-1:0] entry_im;
   } s2_type;

endpackage

// ===== hdl/ctli_if.sv =====
// ---------------------------------------------------------------------------
// ctli channel interfaces
// Valid/ready channels for request items, response items and register
// writes.
// ---------------------------------------------------------------------------
interface ctli_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic [ctli_pkg::INDEX_W-1:0]         entry_index;
   logic signed [ctli_pkg::SAMPLE_W-1:0] entry_re;
   logic signed [ctli_pkg::SAMPLE_W-1:0] entry_im;
   logic signed [ctli_pkg::COORD_W-1:0]  x;

   modport source (output valid, func, entry_index, entry_re, entry_im, x, input ready);
   modport sink   (input valid, func, entry_index, entry_re, entry_im, x, output ready);
endinterface

interface ctli_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ctli_pkg::SAMPLE_W-1:0] result_re;
   logic signed [ctli_pkg::SAMPLE_W-1:0] result_im;
   logic                                 in_range;

   modport source (output valid, result_re, result_im, in_range, input ready);
   modport sink   (input valid, result_re, result_im, in_range, output ready);
endinterface

interface ctli_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ctli_pkg::CSR_INDEX_W-1:0]   index;
   logic [ctli_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/complex_table_linear_interp.sv =====
// ---------------------------------------------------------------------------
// complex_table_linear_interp
// Sustains one item per cycle, unless the response side stalls, through the
// offset, multiply, table read and blend stages.
// Write items give no response and are seen by every later query.
// Reset clears the stage valid bits and the configuration registers; table
// entries hold no defined value until written.
// ---------------------------------------------------------------------------
module complex_table_linear_interp #(
   parameter int TABLE_DEPTH = ctli_pkg::TABLE_DEPTH,
   parameter int FRAC_BITS   = ctli_pkg::FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   ctli_req_if.sink   req_if,
   ctli_rsp_if.source rsp_if,
   ctli_csr_if.sink   csr_if
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = ctli_pkg::COORD_W;
   localparam int SW    = ctli_pkg::SAMPLE_W;
   localparam int CMP_W = CW + 1;

   ctli_pkg::cfg_type cfg;
   ctli_pkg::s2_type  s2;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic en1, en2, en3, en4;

   logic [CMP_W-1:0]     idx_ext;
   logic [CMP_W-1:0]     n_ext;
   logic                 beyond;
   logic [AW-1:0]        raddr_a;
   logic [AW-1:0]        raddr_b;
   logic [CW-1:0]        widx;
   logic                 wok;
   logic                 ram_we;
   logic [2*SW-1:0]      rdata_a;
   logic [2*SW-1:0]      rdata_b;

   logic                 in_range3_ff, in_range3_in;
   logic [FRAC_BITS-1:0] frac3_ff;
   logic                 in_range4_ff;
   logic signed [SW-1:0] result_re;
   logic signed [SW-1:0] result_im;

   ctli_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   // Each stage moves when it is empty or the stage after it moves.
   always_comb begin
      en4 = !v4_ff || rsp_if.ready;
      en3 = !v3_ff || en4;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
      v1_in = en1 ? req_if.valid : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
      v3_in = en3 ? (v2_ff && (s2.is_query == ctli_pkg::FUNC_QUERY)) : v3_ff;
      v4_in = en4 ? v3_ff : v4_ff;
   end

   assign req_if.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   ctli_pos u_pos (
      .clock       (clock),
      .en1         (en1),
      .en2         (en2),
      .func        (req_if.func),
      .entry_index (req_if.entry_index),
      .entry_re    (req_if.entry_re),
      .entry_im    (req_if.entry_im),
      .x           (req_if.x),
      .cfg         (cfg),
      .s2          (s2)
   );

   // Range check and table access. Writes are applied at the same stage as
   // the reads, so every item sees the table in request order.
   always_comb begin
      idx_ext = {1'b0, s2.prod[ctli_pkg::PROD_W-1:CW]};
      n_ext   = (CMP_W'(cfg.entries_in_use) < CMP_W'(TABLE_DEPTH))
                ? CMP_W'(cfg.entries_in_use) : CMP_W'(TABLE_DEPTH);
      beyond  = (idx_ext + CMP_W'(1)) >= n_ext;
      in_range3_in = !s2.below && !beyond;
      raddr_a = s2.prod[CW +: AW];
      raddr_b = raddr_a + AW'(1);
      widx    = CW'(s2.entry_index);
      wok     = widx < CW'(TABLE_DEPTH);
      ram_we  = en3 && v2_ff && (s2.is_query == ctli_pkg::FUNC_WRITE) && wok;
   end

   ctli_ram #(
      .WIDTH (2 * SW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (widx[AW-1:0]),
      .wdata   ({s2.entry_im, s2.entry_re}),
      .re      (en3),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   always_ff @(posedge clock) begin
      if (en3) begin
         in_range3_ff <= in_range3_in;
         frac3_ff     <= s2.prod[CW-1 -: FRAC_BITS];
      end
      if (en4) begin
         in_range4_ff <= in_range3_ff;
      end
   end

   ctli_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend_re (
      .clock    (clock),
      .en       (en4),
      .in_range (in_range3_ff),
      .frac     (frac3_ff),
      .sample_a (signed'(rdata_a[SW-1:0])),
      .sample_b (signed'(rdata_b[SW-1:0])),
      .result   (result_re)
   );

   ctli_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend_im (
      .clock    (clock),
      .en       (en4),
      .in_range (in_range3_ff),
      .frac     (frac3_ff),
      .sample_a (signed'(rdata_a[2*SW-1:SW])),
      .sample_b (signed'(rdata_b[2*SW-1:SW])),
      .result   (result_im)
   );

   assign rsp_if.valid     = v4_ff;
   assign rsp_if.result_re = result_re;
   assign rsp_if.result_im = result_im;
   assign rsp_if.in_range  = in_range4_ff;

   // An item outside the grid always comes out as zero.
   a_zero_outside: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.in_range) |->
         (rsp_if.result_re == '0) && (rsp_if.result_im == '0))
      else $error("out-of-range response carries a nonzero value");

   // A write item leaving the multiply stage never becomes a response.
   a_write_drops: assert property (@(posedge clock) disable iff (reset)
      (en3 && v2_ff && (s2.is_query == ctli_pkg::FUNC_WRITE)) |=> !v3_ff)
      else $error("write item entered the read stage as valid");

   // Read data of a held stage stays put while the pipeline is stalled.
   a_read_hold: assert property (@(posedge clock) disable iff (reset)
      !en3 |=> ($stable(rdata_a) && $stable(rdata_b)))
      else $error("table read data changed during a stall");

   // The request side only backs up when every stage is full and blocked.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_if.ready))
      else $error("request stalled while a stage was free");

endmodule

// ===== hdl/ctli_ram.sv =====
// ---------------------------------------------------------------------------
// ctli_ram
// Generic RAM with one write port and two registered read ports.
// ---------------------------------------------------------------------------
module ctli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_a_ff <= mem[raddr_a];
         rdata_b_ff <= mem[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ===== hdl/ctli_csr.sv =====
// ---------------------------------------------------------------------------
// ctli_csr
// Configuration registers: grid start, inverse step and entry count.
// ---------------------------------------------------------------------------
module ctli_csr (
   input  logic              clock,
   input  logic              reset,
   ctli_csr_if.sink          csr_if,
   output ctli_pkg::cfg_type cfg
);

   ctli_pkg::cfg_type cfg_ff;
   ctli_pkg::cfg_type cfg_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            ctli_pkg::REG_X_MIN:          cfg_in.x_min = signed'(csr_if.data);
            ctli_pkg::REG_INV_STEP:       cfg_in.inv_step = csr_if.data;
            ctli_pkg::REG_ENTRIES_IN_USE: cfg_in.entries_in_use =
                                             csr_if.data[ctli_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_min          <= ctli_pkg::X_MIN_RESET;
         cfg_ff.inv_step       <= ctli_pkg::INV_STEP_RESET;
         cfg_ff.entries_in_use <= ctli_pkg::ENTRIES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/ctli_pos.sv =====
// ---------------------------------------------------------------------------
// ctli_pos
// First two pipeline stages: offset from the grid start, then scaling by
// the inverse step into a grid position.
// ---------------------------------------------------------------------------
module ctli_pos (
   input  logic                                 clock,
   input  logic                                 en1,
   input  logic                                 en2,
   input  logic                                 func,
   input  logic [ctli_pkg::INDEX_W-1:0]         entry_index,
   input  logic signed [ctli_pkg::SAMPLE_W-1:0] entry_re,
   input  logic signed [ctli_pkg::SAMPLE_W-1:0] entry_im,
   input  logic signed [ctli_pkg::COORD_W-1:0]  x,
   input  ctli_pkg::cfg_type                    cfg,
   output ctli_pkg::s2_type                     s2
);

   ctli_pkg::s1_type s1_ff;
   ctli_pkg::s1_type s1_in;
   ctli_pkg::s2_type s2_ff;
   ctli_pkg::s2_type s2_in;

   always_comb begin
      s1_in.is_query    = (func == ctli_pkg::FUNC_QUERY);
      // Exact 33-bit difference, so a negative offset is never lost.
      s1_in.diff        = {x[ctli_pkg::COORD_W-1], x}
                          - {cfg.x_min[ctli_pkg::COORD_W-1], cfg.x_min};
      s1_in.entry_index = entry_index;
      s1_in.entry_re    = entry_re;
      s1_in.entry_im    = entry_im;
   end

   always_comb begin
      s2_in.is_query    = s1_ff.is_query;
      s2_in.below       = s1_ff.diff[ctli_pkg::COORD_W];
      s2_in.prod        = ctli_pkg::PROD_W'(s1_ff.diff[ctli_pkg::COORD_W-1:0])
                          * ctli_pkg::PROD_W'(cfg.inv_step);
      s2_in.entry_index = s1_ff.entry_index;
      s2_in.entry_re    = s1_ff.entry_re;
      s2_in.entry_im    = s1_ff.entry_im;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
      if (en2) begin
         s2_ff <= s2_in;
      end
   end

   assign s2 = s2_ff;

endmodule

// ===== hdl/ctli_blend.sv =====
// ---------------------------------------------------------------------------
// ctli_blend
// Last pipeline stage for one component: weighted blend of two adjacent
// samples, floored to Q1.15, forced to zero outside the grid.
// ---------------------------------------------------------------------------
module ctli_blend #(
   parameter int FRAC_BITS = ctli_pkg::FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic                                 in_range,
   input  logic [FRAC_BITS-1:0]                 frac,
   input  logic signed [ctli_pkg::SAMPLE_W-1:0] sample_a,
   input  logic signed [ctli_pkg::SAMPLE_W-1:0] sample_b,
   output logic signed [ctli_pkg::SAMPLE_W-1:0] result
);

   localparam int SW    = ctli_pkg::SAMPLE_W;
   localparam int ACC_W = FRAC_BITS + SW + 2;

   logic signed [SW:0]        diff;
   logic signed [FRAC_BITS:0] frac_s;
   logic signed [ACC_W-1:0]   base;
   logic signed [ACC_W-1:0]   acc;
   logic signed [SW-1:0]      result_ff;
   logic signed [SW-1:0]      result_in;

   // a*(1-f) + b*f is rewritten as a + (b-a)*f, one multiply per component.
   always_comb begin
      diff      = {sample_b[SW-1], sample_b} - {sample_a[SW-1], sample_a};
      frac_s    = signed'({1'b0, frac});
      base      = ACC_W'(sample_a) <<< FRAC_BITS;
      acc       = base + ACC_W'(diff) * ACC_W'(frac_s);
      result_in = in_range ? acc[FRAC_BITS +: SW] : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== sim/ctli_checker.sv =====
// ---------------------------------------------------------------------------
// ctli_checker
// Watches the request, response and register channels of the complex table
// interpolator, keeps its own copy of the grid registers and the sample
// table, computes the expected sample for every accepted query and compares
// each response against the oldest outstanding expectation.
// ---------------------------------------------------------------------------
module ctli_checker (
   input  logic clock,
   input  logic reset,
   ctli_req_if  req_if,
   ctli_rsp_if  rsp_if,
   ctli_csr_if  csr_if,
   output int   fail_count,
   output int   pending
);

   typedef struct packed {
      logic signed [ctli_pkg::COORD_W-1:0]  coord;
      logic signed [ctli_pkg::SAMPLE_W-1:0] re;
      logic signed [ctli_pkg::SAMPLE_W-1:0] im;
      logic                                 in_range;
   } sample_expect_type;

   logic signed [ctli_pkg::COORD_W-1:0]  grid_x_min;
   logic [ctli_pkg::COORD_W-1:0]         grid_inv_step;
   logic [ctli_pkg::COUNT_W-1:0]         grid_entries;
   logic signed [ctli_pkg::SAMPLE_W-1:0] mem_re [ctli_pkg::TABLE_DEPTH];
   logic signed [ctli_pkg::SAMPLE_W-1:0] mem_im [ctli_pkg::TABLE_DEPTH];
   sample_expect_type                    expected_samples [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Weighted sum of two neighbors, floored back to Q1.15.
   function automatic logic signed [ctli_pkg::SAMPLE_W-1:0] blend_part(
      input logic signed [ctli_pkg::SAMPLE_W-1:0] lower,
      input logic signed [ctli_pkg::SAMPLE_W-1:0] upper,
      input logic [ctli_pkg::FRAC_BITS-1:0]       frac
   );
      longint acc;
      acc = longint'(lower) * ((longint'(1) << ctli_pkg::FRAC_BITS) - longint'(frac))
          + longint'(upper) * longint'(frac);
      acc = acc >>> ctli_pkg::FRAC_BITS;
      return acc[ctli_pkg::SAMPLE_W-1:0];
   endfunction

   function automatic sample_expect_type interpolate(
      input logic signed [ctli_pkg::COORD_W-1:0] xq
   );
      logic signed [ctli_pkg::COORD_W:0]    offset;
      logic [ctli_pkg::PROD_W-1:0]          prod;
      logic [ctli_pkg::COORD_W-1:0]         base;
      logic [ctli_pkg::FRAC_BITS-1:0]       frac;
      longint                               span;
      sample_expect_type                    r;
      r       = '0;
      r.coord = xq;
      offset  = $signed({xq[ctli_pkg::COORD_W-1], xq})
              - $signed({grid_x_min[ctli_pkg::COORD_W-1], grid_x_min});
      if (offset < 0) return r;
      prod = {32'b0, offset[ctli_pkg::COORD_W-1:0]} * {32'b0, grid_inv_step};
      // Position keeps FRAC_BITS fraction bits; the integer part picks the entry.
      base = prod[ctli_pkg::PROD_W-1:32];
      frac = prod[31:32-ctli_pkg::FRAC_BITS];
      span = (grid_entries > ctli_pkg::TABLE_DEPTH) ? ctli_pkg::TABLE_DEPTH : grid_entries;
      if (longint'(base) + 1 >= span) return r;
      r.re       = blend_part(mem_re[base], mem_re[base+1], frac);
      r.im       = blend_part(mem_im[base], mem_im[base+1], frac);
      r.in_range = 1'b1;
      return r;
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   always @(posedge clock) begin
      sample_expect_type want;
      if (reset) begin
         grid_x_min    = ctli_pkg::X_MIN_RESET;
         grid_inv_step = ctli_pkg::INV_STEP_RESET;
         grid_entries  = ctli_pkg::ENTRIES_RESET;
         expected_samples.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (ctli_pkg::csr_reg_type'(csr_if.index))
               ctli_pkg::REG_X_MIN:          grid_x_min    = csr_if.data;
               ctli_pkg::REG_INV_STEP:       grid_inv_step = csr_if.data;
               ctli_pkg::REG_ENTRIES_IN_USE:
                  grid_entries = csr_if.data[ctli_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
         // Responses are checked before this edge's request, which cannot
         // have produced one yet.
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_samples.size() == 0) begin
               note_failure($sformatf("unexpected response: re %0d im %0d in_range %0b",
                  rsp_if.result_re, rsp_if.result_im, rsp_if.in_range));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_if.result_re !== want.re || rsp_if.result_im !== want.im ||
                   rsp_if.in_range !== want.in_range) begin
                  note_failure($sformatf(
                     "x %0d: expected re %0d im %0d in_range %0b, got re %0d im %0d in_range %0b",
                     want.coord, want.re, want.im, want.in_range,
                     rsp_if.result_re, rsp_if.result_im, rsp_if.in_range));
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (req_if.func == ctli_pkg::FUNC_WRITE) begin
               mem_re[req_if.entry_index] = req_if.entry_re;
               mem_im[req_if.entry_index] = req_if.entry_im;
            end else begin
               expected_samples.push_back(interpolate(req_if.x));
            end
         end
      end
      pending = expected_samples.size();
   end

endmodule

// ===== sim/complex_table_linear_interp_tb.sv =====
// ---------------------------------------------------------------------------
// complex_table_linear_interp_tb
// Drives table writes and coordinate queries through several grid settings,
// with random gaps on the request side and random stalls on the response
// side, and reports the verdict of the attached checker.
// ---------------------------------------------------------------------------
module complex_table_linear_interp_tb;

   localparam int DRAIN_CYCLES     = 10;
   localparam int LONG_HOLD_CYCLES = 60;

   logic clock = 1'b0;
   logic reset;

   ctli_req_if req_if ();
   ctli_rsp_if rsp_if ();
   ctli_csr_if csr_if ();

   int fail_count;
   int pending;
   bit idle_on;
   bit hold_req;

   // Grid currently loaded, used to aim queries and to avoid unwritten reads.
   logic signed [ctli_pkg::COORD_W-1:0] cur_x_min;
   logic [ctli_pkg::COORD_W-1:0]        cur_inv_step;
   int unsigned                         cur_entries;
   bit                                  written [ctli_pkg::TABLE_DEPTH];

   complex_table_linear_interp dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   ctli_checker interp_check (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_if     (csr_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   initial begin : watchdog
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : rsp_pacing
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
            for (int c = 0; c < LONG_HOLD_CYCLES; c++) @(posedge clock);
            hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   function automatic logic signed [ctli_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [ctli_pkg::FRAC_BITS-1:0] pick_frac();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Entry that a query would read, if it lands inside the grid.
   function automatic bit reads_entry(input logic signed [ctli_pkg::COORD_W-1:0] xq,
                                      output int unsigned base);
      longint                      offset;
      logic [ctli_pkg::PROD_W-1:0] prod;
      base   = 0;
      offset = longint'(xq) - longint'(cur_x_min);
      if (offset < 0) return 1'b0;
      prod = {32'b0, offset[31:0]} * {32'b0, cur_inv_step};
      if (prod[ctli_pkg::PROD_W-1:32] + 64'd1 >= cur_entries) return 1'b0;
      base = prod[ctli_pkg::PROD_W-1:32];
      return 1'b1;
   endfunction

   // Coordinate whose grid position is at or just past target + frac.
   function automatic logic signed [ctli_pkg::COORD_W-1:0] aim_at(
      input int unsigned target,
      input logic [ctli_pkg::FRAC_BITS-1:0] frac
   );
      longint spot;
      longint offset;
      longint xq;
      spot = (longint'(target) << 32) + (longint'(frac) << (32 - ctli_pkg::FRAC_BITS));
      if (cur_inv_step == 0)
         offset = $urandom_range(0, 32'h000F_FFFF);
      else
         offset = (spot + longint'(cur_inv_step) - 1) / longint'(cur_inv_step);
      xq = longint'(cur_x_min) + offset;
      if (xq > longint'(2147483647)) return $urandom;
      return xq[ctli_pkg::COORD_W-1:0];
   endfunction

   task automatic send_item(input logic fn, input logic [ctli_pkg::INDEX_W-1:0] idx,
                            input logic signed [ctli_pkg::SAMPLE_W-1:0] re,
                            input logic signed [ctli_pkg::SAMPLE_W-1:0] im,
                            input logic signed [ctli_pkg::COORD_W-1:0] xq);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.func        <= fn;
      req_if.entry_index <= idx;
      req_if.entry_re    <= re;
      req_if.entry_im    <= im;
      req_if.x           <= xq;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_write(input int unsigned idx,
                             input logic signed [ctli_pkg::SAMPLE_W-1:0] re,
                             input logic signed [ctli_pkg::SAMPLE_W-1:0] im);
      written[idx] = 1'b1;
      send_item(ctli_pkg::FUNC_WRITE, idx, re, im, $urandom);
   endtask

   // Entries that a query will read are written first if they never were.
   task automatic send_query(input logic signed [ctli_pkg::COORD_W-1:0] xq);
      int unsigned base;
      if (reads_entry(xq, base)) begin
         for (int k = 0; k < 2; k++)
            if (!written[base+k]) send_write(base + k, pick_sample(), pick_sample());
      end
      send_item(ctli_pkg::FUNC_QUERY, $urandom, $urandom, $urandom, xq);
   endtask

   task automatic write_reg(input ctli_pkg::csr_reg_type r,
                            input logic [ctli_pkg::CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= r;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   task automatic load_grid(input logic signed [ctli_pkg::COORD_W-1:0] x_min,
                            input logic [ctli_pkg::COORD_W-1:0] inv_step,
                            input int unsigned entries);
      cur_x_min    = x_min;
      cur_inv_step = inv_step;
      cur_entries  = entries;
      write_reg(ctli_pkg::REG_X_MIN, x_min);
      write_reg(ctli_pkg::REG_INV_STEP, inv_step);
      write_reg(ctli_pkg::REG_ENTRIES_IN_USE, entries);
      csr_if.valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_item();
      int unsigned pick;
      int unsigned target;
      logic signed [ctli_pkg::COORD_W-1:0] xq;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         send_write($urandom_range(0, ctli_pkg::TABLE_DEPTH - 1), pick_sample(),
                    pick_sample());
      end else if (pick < 60) begin
         case ($urandom_range(0, 9))
            0:       target = 0;
            1:       target = cur_entries - 2;
            default: target = $urandom_range(0, cur_entries - 2);
         endcase
         send_query(aim_at(target, pick_frac()));
      end else if (pick < 72) begin
         if (longint'(cur_x_min) - 64'sd131072 < -64'sd2147483648)
            xq = $urandom;
         else
            xq = cur_x_min - $signed(32'($urandom_range(1, 32'h0002_0000)));
         send_query(xq);
      end else if (pick < 84) begin
         send_query(aim_at(cur_entries - 1 + $urandom_range(0, 3), pick_frac()));
      end else begin
         send_query($urandom);
      end
   endtask

   task automatic run_phase(input logic signed [ctli_pkg::COORD_W-1:0] x_min,
                            input logic [ctli_pkg::COORD_W-1:0] inv_step,
                            input int unsigned entries, input int count);
      load_grid(x_min, inv_step, entries);
      repeat (count) random_item();
      req_if.valid <= 1'b0;
      drain();
   endtask

   initial begin : stimulus
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.func        <= ctli_pkg::FUNC_WRITE;
      req_if.entry_index <= '0;
      req_if.entry_re    <= '0;
      req_if.entry_im    <= '0;
      req_if.x           <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= ctli_pkg::REG_X_MIN;
      csr_if.data        <= '0;
      idle_on  = 1'b1;
      hold_req = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items on the reset grid: one entry per 0x10000 of coordinate.
      load_grid(ctli_pkg::X_MIN_RESET, ctli_pkg::INV_STEP_RESET, ctli_pkg::ENTRIES_RESET);
      send_write(0, 16'sh8000, 16'sh7FFF);
      send_write(1, 16'sh7FFF, 16'sh8000);
      send_write(2, 16'sh0000, -16'sd1);
      send_write(ctli_pkg::TABLE_DEPTH - 2, 16'sd12345, -16'sd12345);
      send_write(ctli_pkg::TABLE_DEPTH - 1, 16'sh8000, 16'sh8000);
      send_query(32'sh0000_0000);
      send_query(32'sh0000_FFFF);
      send_query(32'sh0000_8000);
      send_query(32'sh0001_0000);
      send_query(32'sh0001_8000);
      send_query(32'sh03FE_0000);
      // Last pair of entries, largest fraction.
      send_query(32'sh03FE_FFFF);
      // Beyond the last pair of entries.
      send_query(32'sh03FF_0000);
      send_query(32'sh7FFF_FFFF);
      // Below the grid start.
      send_query(-32'sd1);
      send_query(32'sh8000_0000);
      send_write(ctli_pkg::TABLE_DEPTH - 1, 16'sh7FFF, 16'sh7FFF);
      send_query(32'sh03FE_8000);
      req_if.valid <= 1'b0;
      drain();

      run_phase(ctli_pkg::X_MIN_RESET, ctli_pkg::INV_STEP_RESET, ctli_pkg::ENTRIES_RESET, 40);
      run_phase(32'sh8000_0000, 32'h0000_0000, 2, 50);
      run_phase(32'sh7FFF_0000, 32'hFFFF_FFFF, ctli_pkg::TABLE_DEPTH, 50);
      hold_req = 1'b1;
      run_phase($urandom, $urandom_range(32'h0000_1000, 32'h0040_0000),
                $urandom_range(3, ctli_pkg::TABLE_DEPTH), 50);
      run_phase(-32'sh0001_0000, 32'h0000_8000, 16, 40);
      run_phase(32'sh7FFF_FFFF, ctli_pkg::INV_STEP_RESET, 2, 15);
      idle_on = 1'b0;
      run_phase($urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000,
                $urandom_range(32'h0000_4000, 32'h0008_0000),
                $urandom_range(2, ctli_pkg::TABLE_DEPTH), 50);

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
